// ----- rtl/tec_pkg.sv -----
// -----------------------------------------------------------------------------
// tec_pkg: shared constants and types of the two-level exclusive cache.
// Holds the default geometry, the register indexes and the geometry bundle.
// -----------------------------------------------------------------------------
package tec_pkg;

  // Default sizes of the block.
  localparam int unsigned ADDR_BITS_DEF   = 48;
  localparam int unsigned L1_MAX_SETS_DEF = 64;
  localparam int unsigned L1_MAX_WAYS_DEF = 8;
  localparam int unsigned L2_MAX_SETS_DEF = 512;
  localparam int unsigned L2_MAX_WAYS_DEF = 16;

  // Configuration port, counter and stamp widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned STAMP_W    = 32;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L1_SET_BITS = 3'd0,
    REG_L1_WAYS     = 3'd1,
    REG_L2_SET_BITS = 3'd2,
    REG_L2_WAYS     = 3'd3,
    REG_BLOCK_BITS  = 3'd4,
    REG_L1_LRU      = 3'd5
  } reg_idx_e;

  // Effective geometry after clamping.
  typedef struct packed {
    logic [4:0] blk;
    logic [4:0] s1;
    logic [4:0] s2;
    logic [5:0] w1;
    logic [5:0] w2;
  } geom_t;

endpackage

// ----- rtl/tec_if.sv -----
// -----------------------------------------------------------------------------
// tec_if: request and response channels of the two-level exclusive cache.
// Both carry valid, ready and the payload of one transaction.
// -----------------------------------------------------------------------------
interface tec_req_if #(
  parameter int unsigned ADDR_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output req_type, output address, input ready);
  modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface tec_rsp_if;
  logic        valid;
  logic        ready;
  logic        l1_hit;
  logic        l2_hit;
  logic        mem_read;
  logic        mem_write;
  logic [31:0] mem_read_count;
  logic [31:0] mem_write_count;
  logic [31:0] l1_hit_count;
  logic [31:0] l1_miss_count;
  logic [31:0] l2_hit_count;
  logic [31:0] l2_miss_count;

  modport source (output valid, output l1_hit, output l2_hit, output mem_read,
                  output mem_write, output mem_read_count, output mem_write_count,
                  output l1_hit_count, output l1_miss_count, output l2_hit_count,
                  output l2_miss_count, input ready);
  modport sink   (input valid, input l1_hit, input l2_hit, input mem_read,
                  input mem_write, input mem_read_count, input mem_write_count,
                  input l1_hit_count, input l1_miss_count, input l2_hit_count,
                  input l2_miss_count, output ready);
endinterface

// ----- rtl/two_level_exclusive_cache.sv -----
// -----------------------------------------------------------------------------
// two_level_exclusive_cache: two-level exclusive set-associative cache model.
// An L1 hit reads and checks the L1 row; an L1 miss then checks the L2 set and
// fills L1, and an L1 eviction also reads the victim's L2 set, with an oldest-way
// scan when that set is full. One access at a time: the next request is taken only
// after the response is loaded. After reset a clearing pass over max(L1_MAX_SETS,
// L2_MAX_SETS) rows (512 by default) wipes both set memories; requests wait for it.
// -----------------------------------------------------------------------------
module two_level_exclusive_cache
  import tec_pkg::*;
#(
  parameter int unsigned ADDR_BITS   = ADDR_BITS_DEF,
  parameter int unsigned L1_MAX_SETS = L1_MAX_SETS_DEF,
  parameter int unsigned L1_MAX_WAYS = L1_MAX_WAYS_DEF,
  parameter int unsigned L2_MAX_SETS = L2_MAX_SETS_DEF,
  parameter int unsigned L2_MAX_WAYS = L2_MAX_WAYS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tec_req_if.sink               req_i,
  tec_rsp_if.source             rsp_o
);

  localparam int unsigned WAY_W    = 1 + ADDR_BITS + STAMP_W;
  localparam int unsigned L1_ROW_W = L1_MAX_WAYS * WAY_W;
  localparam int unsigned L2_ROW_W = L2_MAX_WAYS * WAY_W;
  localparam int unsigned L1_SET_W = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
  localparam int unsigned L2_SET_W = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
  localparam int unsigned L1_SB_MAX = $clog2(L1_MAX_SETS + 1) - 1;
  localparam int unsigned L2_SB_MAX = $clog2(L2_MAX_SETS + 1) - 1;
  localparam int unsigned L1_WI_W  = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
  localparam int unsigned L2_WI_W  = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
  localparam int unsigned SCAN_W   = $clog2(L2_MAX_WAYS + 1);
  localparam int unsigned CLR_N    = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
  localparam int unsigned CLR_W    = $clog2(CLR_N + 1);

  // Sequencer states.
  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_L1RD   = 4'd2;
  localparam logic [3:0] ST_L1CHK  = 4'd3;
  localparam logic [3:0] ST_L2CHK  = 4'd4;
  localparam logic [3:0] ST_V2RD   = 4'd5;
  localparam logic [3:0] ST_V2CHK  = 4'd6;
  localparam logic [3:0] ST_V2SCAN = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0] state_q, state_d;
  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;

  // Configuration registers.
  logic [2:0] l1_set_bits_q;
  logic [3:0] l1_ways_q;
  logic [3:0] l2_set_bits_q;
  logic [4:0] l2_ways_q;
  logic [4:0] block_bits_q;
  logic       l1_lru_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_set_bits_q <= 3'd6;
      l1_ways_q     <= 4'd8;
      l2_set_bits_q <= 4'd9;
      l2_ways_q     <= 5'd16;
      block_bits_q  <= 5'd6;
      l1_lru_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_L1_SET_BITS: l1_set_bits_q <= cfg_data_i[2:0];
        REG_L1_WAYS:     l1_ways_q     <= cfg_data_i[3:0];
        REG_L2_SET_BITS: l2_set_bits_q <= cfg_data_i[3:0];
        REG_L2_WAYS:     l2_ways_q     <= cfg_data_i[4:0];
        REG_BLOCK_BITS:  block_bits_q  <= cfg_data_i[4:0];
        REG_L1_LRU:      l1_lru_q      <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the register values to the built geometry.
  geom_t geom;
  always_comb begin
    geom.blk = (block_bits_q > 5'd16) ? 5'd16 : block_bits_q;
    geom.s1  = ({2'b0, l1_set_bits_q} > 5'(L1_SB_MAX)) ? 5'(L1_SB_MAX)
                                                        : {2'b0, l1_set_bits_q};
    geom.s2  = ({1'b0, l2_set_bits_q} > 5'(L2_SB_MAX)) ? 5'(L2_SB_MAX)
                                                        : {1'b0, l2_set_bits_q};
    if (l1_ways_q == 4'd0) geom.w1 = 6'd1;
    else if ({2'b0, l1_ways_q} > 6'(L1_MAX_WAYS)) geom.w1 = 6'(L1_MAX_WAYS);
    else geom.w1 = {2'b0, l1_ways_q};
    if (l2_ways_q == 5'd0) geom.w2 = 6'd1;
    else if ({1'b0, l2_ways_q} > 6'(L2_MAX_WAYS)) geom.w2 = 6'(L2_MAX_WAYS);
    else geom.w2 = {1'b0, l2_ways_q};
  end

  // Request registers.
  logic                 write_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 h1_q, h1_d, h2_q, h2_d;
  logic [ADDR_BITS-1:0] vline_q, vline_d;
  logic [STAMP_W-1:0]   now_q;

  logic [ADDR_BITS-1:0] tag1, tag2, vtag2;
  logic [L1_SET_W-1:0]  set1;
  logic [L2_SET_W-1:0]  set2, vset2;

  tec_split #(.ADDR_BITS(ADDR_BITS), .SET_W(L1_SET_W)) u_split1 (
    .addr_i(addr_q), .blk_i(geom.blk), .sbits_i(geom.s1), .tag_o(tag1), .set_o(set1)
  );
  tec_split #(.ADDR_BITS(ADDR_BITS), .SET_W(L2_SET_W)) u_split2 (
    .addr_i(addr_q), .blk_i(geom.blk), .sbits_i(geom.s2), .tag_o(tag2), .set_o(set2)
  );
  tec_split #(.ADDR_BITS(ADDR_BITS), .SET_W(L2_SET_W)) u_splitv (
    .addr_i(vline_q), .blk_i(geom.blk), .sbits_i(geom.s2), .tag_o(vtag2), .set_o(vset2)
  );

  // Set memories.
  logic                l1_we, l1_re, l2_we, l2_re;
  logic [L1_SET_W-1:0] l1_waddr;
  logic [L2_SET_W-1:0] l2_waddr, l2_raddr;
  logic [L1_ROW_W-1:0] l1_wdata, l1_rdata;
  logic [L2_ROW_W-1:0] l2_wdata, l2_rdata;

  tec_ram #(.WIDTH(L1_ROW_W), .DEPTH(L1_MAX_SETS)) u_l1_ram (
    .clk_i, .we_i(l1_we), .waddr_i(l1_waddr), .wdata_i(l1_wdata),
    .re_i(l1_re), .raddr_i(set1), .rdata_o(l1_rdata)
  );
  tec_ram #(.WIDTH(L2_ROW_W), .DEPTH(L2_MAX_SETS)) u_l2_ram (
    .clk_i, .we_i(l2_we), .waddr_i(l2_waddr), .wdata_i(l2_wdata),
    .re_i(l2_re), .raddr_i(l2_raddr), .rdata_o(l2_rdata)
  );

  // L1 row search: hit, first free way and oldest way.
  logic               l1_hit, l1_inv_found;
  logic [L1_WI_W-1:0] l1_hit_way, l1_inv_way, l1_vic_way;
  logic [STAMP_W-1:0] l1_best;
  logic [WAY_W-1:0]   l1_way;
  always_comb begin
    l1_hit = 1'b0; l1_hit_way = '0; l1_inv_found = 1'b0; l1_inv_way = '0;
    l1_vic_way = '0;
    l1_best = l1_rdata[STAMP_W-1:0];
    for (int i = L1_MAX_WAYS - 1; i >= 0; i--) begin
      l1_way = l1_rdata[i*WAY_W +: WAY_W];
      if (6'(i) < geom.w1) begin
        if (l1_way[WAY_W-1] && l1_way[STAMP_W +: ADDR_BITS] == tag1) begin
          l1_hit = 1'b1; l1_hit_way = L1_WI_W'(i);
        end
        if (!l1_way[WAY_W-1]) begin
          l1_inv_found = 1'b1; l1_inv_way = L1_WI_W'(i);
        end
      end
    end
    for (int i = 1; i < L1_MAX_WAYS; i++) begin
      l1_way = l1_rdata[i*WAY_W +: WAY_W];
      if (6'(i) < geom.w1 && l1_way[STAMP_W-1:0] < l1_best) begin
        l1_best = l1_way[STAMP_W-1:0]; l1_vic_way = L1_WI_W'(i);
      end
    end
  end

  // L2 row search: hit on the request tag and first free way.
  logic               l2_hit, l2_inv_found;
  logic [L2_WI_W-1:0] l2_hit_way, l2_inv_way;
  logic [WAY_W-1:0]   l2_way;
  always_comb begin
    l2_hit = 1'b0; l2_hit_way = '0; l2_inv_found = 1'b0; l2_inv_way = '0;
    for (int i = L2_MAX_WAYS - 1; i >= 0; i--) begin
      l2_way = l2_rdata[i*WAY_W +: WAY_W];
      if (6'(i) < geom.w2) begin
        if (l2_way[WAY_W-1] && l2_way[STAMP_W +: ADDR_BITS] == tag2) begin
          l2_hit = 1'b1; l2_hit_way = L2_WI_W'(i);
        end
        if (!l2_way[WAY_W-1]) begin
          l2_inv_found = 1'b1; l2_inv_way = L2_WI_W'(i);
        end
      end
    end
  end

  // Oldest-way scan over the victim's L2 set, one way per cycle.
  logic [SCAN_W-1:0]  scan_q, scan_d;
  logic [L2_WI_W-1:0] best_q, best_d;
  logic [STAMP_W-1:0] scan_stamp, best_stamp;
  assign scan_stamp = l2_rdata[scan_q[L2_WI_W-1:0]*WAY_W +: STAMP_W];
  assign best_stamp = l2_rdata[best_q*WAY_W +: STAMP_W];

  // Counters and response register.
  logic [CNT_W-1:0] c_mrd_q, c_mwr_q, c_l1h_q, c_l1m_q, c_l2h_q, c_l2m_q;
  logic [CNT_W-1:0] c_mrd_d, c_mwr_d, c_l1h_d, c_l1m_d, c_l2h_d, c_l2m_d;
  logic             rsp_valid_q, rsp_load;
  logic             r_l1h_q, r_l2h_q, r_mrd_q, r_mwr_q;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v, logic en);
    return (en && v != '1) ? v + 1'b1 : v;
  endfunction

  assign rsp_load = (state_q == ST_OUT) && (!rsp_valid_q || rsp_o.ready);
  always_comb begin
    c_l1h_d = sat_inc(c_l1h_q, h1_q);
    c_l1m_d = sat_inc(c_l1m_q, !h1_q);
    c_l2h_d = sat_inc(c_l2h_q, !h1_q && h2_q);
    c_l2m_d = sat_inc(c_l2m_q, !h1_q && !h2_q);
    c_mrd_d = sat_inc(c_mrd_q, !h1_q && !h2_q);
    c_mwr_d = sat_inc(c_mwr_q, write_q);
  end

  assign req_i.ready = (state_q == ST_IDLE);

  // Sequencer and memory port control.
  logic [WAY_W-1:0] new_way;
  always_comb begin
    state_d = state_q; clr_cnt_d = clr_cnt_q;
    h1_d = h1_q; h2_d = h2_q; vline_d = vline_q;
    scan_d = scan_q; best_d = best_q;
    l1_we = 1'b0; l1_re = 1'b0; l1_waddr = set1; l1_wdata = l1_rdata;
    l2_we = 1'b0; l2_re = 1'b0; l2_waddr = vset2; l2_wdata = l2_rdata;
    l2_raddr = vset2;
    new_way = '0;
    case (state_q)
      ST_CLR: begin
        l1_wdata = '0; l2_wdata = '0;
        l1_waddr = L1_SET_W'(clr_cnt_q); l2_waddr = L2_SET_W'(clr_cnt_q);
        l1_we = (clr_cnt_q < CLR_W'(L1_MAX_SETS));
        l2_we = (clr_cnt_q < CLR_W'(L2_MAX_SETS));
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_W'(CLR_N - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          h1_d = 1'b0; h2_d = 1'b0; state_d = ST_L1RD;
        end
      end
      ST_L1RD: begin
        l1_re = 1'b1; state_d = ST_L1CHK;
      end
      ST_L1CHK: begin
        if (l1_hit) begin
          h1_d = 1'b1;
          new_way = {1'b1, l1_rdata[l1_hit_way*WAY_W + STAMP_W +: ADDR_BITS], now_q};
          l1_wdata[l1_hit_way*WAY_W +: WAY_W] = new_way;
          l1_we = l1_lru_q;
          state_d = ST_OUT;
        end else begin
          l2_raddr = set2; l2_re = 1'b1; state_d = ST_L2CHK;
        end
      end
      ST_L2CHK: begin
        // Exclusive hit: drop the L2 copy.
        if (l2_hit) begin
          h2_d = 1'b1;
          l2_waddr = set2;
          l2_wdata[l2_hit_way*WAY_W + WAY_W - 1] = 1'b0;
          l2_we = 1'b1;
        end
        new_way = {1'b1, tag1, now_q};
        l1_we = 1'b1;
        if (l1_inv_found) begin
          l1_wdata[l1_inv_way*WAY_W +: WAY_W] = new_way;
          state_d = ST_OUT;
        end else begin
          l1_wdata[l1_vic_way*WAY_W +: WAY_W] = new_way;
          vline_d = (l1_rdata[l1_vic_way*WAY_W + STAMP_W +: ADDR_BITS]
                     << ({1'b0, geom.s1} + {1'b0, geom.blk}))
                  | (ADDR_BITS'(set1) << geom.blk);
          state_d = ST_V2RD;
        end
      end
      ST_V2RD: begin
        l2_re = 1'b1; state_d = ST_V2CHK;
      end
      ST_V2CHK: begin
        if (l2_inv_found) begin
          l2_wdata[l2_inv_way*WAY_W +: WAY_W] = {1'b1, vtag2, now_q};
          l2_we = 1'b1;
          state_d = ST_OUT;
        end else begin
          scan_d = SCAN_W'(1); best_d = '0; state_d = ST_V2SCAN;
        end
      end
      ST_V2SCAN: begin
        if ({{(6-SCAN_W){1'b0}}, scan_q} < geom.w2) begin
          if (scan_stamp < best_stamp) best_d = scan_q[L2_WI_W-1:0];
          scan_d = scan_q + 1'b1;
        end else begin
          l2_wdata[best_q*WAY_W +: WAY_W] = {1'b1, vtag2, now_q};
          l2_we = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (rsp_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR; clr_cnt_q <= '0; rsp_valid_q <= 1'b0; now_q <= '0;
      c_mrd_q <= '0; c_mwr_q <= '0; c_l1h_q <= '0;
      c_l1m_q <= '0; c_l2h_q <= '0; c_l2m_q <= '0;
    end else begin
      state_q <= state_d; clr_cnt_q <= clr_cnt_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1; now_q <= now_q + 1'b1;
        c_mrd_q <= c_mrd_d; c_mwr_q <= c_mwr_d; c_l1h_q <= c_l1h_d;
        c_l1m_q <= c_l1m_d; c_l2h_q <= c_l2h_d; c_l2m_q <= c_l2m_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      write_q <= req_i.req_type; addr_q <= req_i.address;
    end
    h1_q <= h1_d; h2_q <= h2_d; vline_q <= vline_d;
    scan_q <= scan_d; best_q <= best_d;
    if (rsp_load) begin
      r_l1h_q <= h1_q; r_l2h_q <= !h1_q && h2_q;
      r_mrd_q <= !h1_q && !h2_q; r_mwr_q <= write_q;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.l1_hit          = r_l1h_q;
  assign rsp_o.l2_hit          = r_l2h_q;
  assign rsp_o.mem_read        = r_mrd_q;
  assign rsp_o.mem_write       = r_mwr_q;
  assign rsp_o.mem_read_count  = c_mrd_q;
  assign rsp_o.mem_write_count = c_mwr_q;
  assign rsp_o.l1_hit_count    = c_l1h_q;
  assign rsp_o.l1_miss_count   = c_l1m_q;
  assign rsp_o.l2_hit_count    = c_l2h_q;
  assign rsp_o.l2_miss_count   = c_l2m_q;

  // No request is taken while the memories are being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLR |-> !req_i.ready)
    else $error("request accepted during clearing pass");

  // A memory read only follows a miss in both levels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && r_mrd_q |-> !r_l1h_q && !r_l2h_q)
    else $error("memory read reported on a hit");

  // An L1 hit only rewrites its row when stamps are refreshed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_L1CHK && l1_we |-> l1_lru_q)
    else $error("L1 row written on a hit in FIFO mode");

  // A new response is loaded only when the previous one is gone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_o.ready |=> $stable(c_l1h_q) && $stable(c_l1m_q))
    else $error("counters moved while a response was stalled");

endmodule

// ----- rtl/tec_ram.sv -----
// -----------------------------------------------------------------------------
// tec_ram: generic single-write, single-read synchronous RAM.
// Read data is registered and holds until the next read.
// -----------------------------------------------------------------------------
module tec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tec_split.sv -----
// -----------------------------------------------------------------------------
// tec_split: address split into tag and set index for one cache level.
// Shifts by the block size and the set bits in use.
// -----------------------------------------------------------------------------
module tec_split
  import tec_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 48,
  parameter int unsigned SET_W     = 6
) (
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [4:0]           blk_i,
  input  logic [4:0]           sbits_i,
  output logic [ADDR_BITS-1:0] tag_o,
  output logic [SET_W-1:0]     set_o
);

  logic [ADDR_BITS-1:0] shifted;
  logic [ADDR_BITS-1:0] mask;
  logic [5:0]           tsh;

  // Tag is what remains above block offset and set index.
  always_comb begin
    shifted = addr_i >> blk_i;
    tsh     = {1'b0, blk_i} + {1'b0, sbits_i};
    tag_o   = addr_i >> tsh;
    mask    = ~({ADDR_BITS{1'b1}} << sbits_i);
    set_o   = SET_W'(shifted & mask);
  end

endmodule

// ----- test/two_level_exclusive_cache_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// two_level_exclusive_cache_tb: self-checking testbench of the two-level cache.
// A directed table opens the run. Random access phases follow, each under its
// own geometry. Every response is checked against an in-bench cache predictor.
// -----------------------------------------------------------------------------
module two_level_exclusive_cache_tb;
  import tec_pkg::*;

  localparam int unsigned ABITS    = 48;
  localparam int unsigned L1_SETS  = 64;
  localparam int unsigned L1_WAYS  = 8;
  localparam int unsigned L2_SETS  = 512;
  localparam int unsigned L2_WAYS  = 16;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned PHASE_N  = 95;
  localparam int unsigned SETTLE   = 40;
  localparam logic        RD       = 1'b0;
  localparam logic        WR       = 1'b1;
  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic        l1_hit;
    logic        l2_hit;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_read_count;
    logic [31:0] mem_write_count;
    logic [31:0] l1_hit_count;
    logic [31:0] l1_miss_count;
    logic [31:0] l2_hit_count;
    logic [31:0] l2_miss_count;
  } cache_rsp_t;

  // One row of the directed table; flags are typed in only where obvious.
  typedef struct {
    logic             wr;
    logic [ABITS-1:0] addr;
    bit               has_flags;
    logic [3:0]       flags;  // l1_hit, l2_hit, mem_read, mem_write
  } dir_row_t;

  // One geometry setting: raw register values, clamping left to the block.
  typedef struct {
    logic [2:0] s1;
    logic [3:0] w1;
    logic [3:0] s2;
    logic [4:0] w2;
    logic [4:0] blk;
    logic       lru;
  } geom_set_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tec_req_if #(.ADDR_BITS(ABITS)) req ();
  tec_rsp_if                      rsp ();

  two_level_exclusive_cache i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req),
    .rsp_o     (rsp)
  );

  // Predictor state: a shadow copy of both cache levels and the counters.
  logic [ABITS-1:0] l1_tag [L1_SETS][L1_WAYS];
  bit               l1_val [L1_SETS][L1_WAYS];
  logic [31:0]      l1_stp [L1_SETS][L1_WAYS];
  logic [ABITS-1:0] l2_tag [L2_SETS][L2_WAYS];
  bit               l2_val [L2_SETS][L2_WAYS];
  logic [31:0]      l2_stp [L2_SETS][L2_WAYS];
  logic [31:0]      access_cnt;
  logic [31:0]      n_mrd, n_mwr, n_l1h, n_l1m, n_l2h, n_l2m;
  logic [2:0]       g_s1 = 3'd6;
  logic [3:0]       g_w1 = 4'd8;
  logic [3:0]       g_s2 = 4'd9;
  logic [4:0]       g_w2 = 5'd16;
  logic [4:0]       g_blk = 5'd6;
  logic             g_lru = 1'b0;

  cache_rsp_t pending_rsp[$];
  int unsigned n_err;
  int unsigned n_sent;
  int unsigned n_seen_l1h, n_seen_l2h, n_seen_mrd;
  bit          quiet;
  logic [ABITS-1:0] pool_base;

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
  end
  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Time limit for the whole run.
  initial begin
    #3ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Computes the response of one access and updates the shadow cache.
  function automatic cache_rsp_t predict_access(logic wr, logic [ABITS-1:0] a);
    cache_rsp_t  r;
    int unsigned b, s1, s2, w1, w2, set1, set2, vset2, vic, slot, i;
    logic [63:0] tag1, tag2, line, vtag2, amask;
    logic [31:0] now;
    bit          placed, hit2;
    amask = (64'd1 << ABITS) - 64'd1;
    b  = (g_blk > 16) ? 16 : g_blk;
    s1 = (g_s1 > 6) ? 6 : g_s1;
    s2 = (g_s2 > 9) ? 9 : g_s2;
    w1 = (g_w1 == 0) ? 1 : ((g_w1 > L1_WAYS) ? L1_WAYS : g_w1);
    w2 = (g_w2 == 0) ? 1 : ((g_w2 > L2_WAYS) ? L2_WAYS : g_w2);
    tag1 = {16'd0, a} >> (b + s1);
    tag2 = {16'd0, a} >> (b + s2);
    set1 = 32'(({16'd0, a} >> b) & ((64'd1 << s1) - 1));
    set2 = 32'(({16'd0, a} >> b) & ((64'd1 << s2) - 1));
    r = '0;
    now = access_cnt;
    placed = 0;
    hit2 = 0;

    // L1 lookup.
    for (i = 0; i < w1; i++) begin
      if (l1_val[set1][i] && l1_tag[set1][i] == tag1[ABITS-1:0]) begin
        r.l1_hit = 1'b1;
        if (g_lru) l1_stp[set1][i] = now;
        break;
      end
    end

    if (r.l1_hit) begin
      n_l1h = sat_inc(n_l1h);
      if (wr) begin
        n_mwr = sat_inc(n_mwr);
        r.mem_write = 1'b1;
      end
    end else begin
      n_l1m = sat_inc(n_l1m);
      // L2 lookup; a hit moves the line out of L2.
      for (i = 0; i < w2; i++) begin
        if (l2_val[set2][i] && l2_tag[set2][i] == tag2[ABITS-1:0]) begin
          hit2 = 1;
          l2_val[set2][i] = 0;
          break;
        end
      end
      if (hit2) begin
        r.l2_hit = 1'b1;
        n_l2h = sat_inc(n_l2h);
      end else begin
        n_l2m = sat_inc(n_l2m);
        n_mrd = sat_inc(n_mrd);
        r.mem_read = 1'b1;
      end
      if (wr) begin
        n_mwr = sat_inc(n_mwr);
        r.mem_write = 1'b1;
      end

      // Fill L1: a free way first, else the oldest stamp.
      for (i = 0; i < w1; i++) begin
        if (!l1_val[set1][i]) begin
          l1_val[set1][i] = 1;
          l1_tag[set1][i] = tag1[ABITS-1:0];
          l1_stp[set1][i] = now;
          placed = 1;
          break;
        end
      end
      if (!placed) begin
        vic = 0;
        for (i = 1; i < w1; i++)
          if (l1_stp[set1][i] < l1_stp[set1][vic]) vic = i;
        line  = (({16'd0, l1_tag[set1][vic]} << (s1 + b)) + (64'(set1) << b)) & amask;
        vtag2 = line >> (b + s2);
        vset2 = 32'((line >> b) & ((64'd1 << s2) - 1));
        l1_tag[set1][vic] = tag1[ABITS-1:0];
        l1_stp[set1][vic] = now;
        // The victim goes to L2: a free way first, else the oldest stamp.
        slot = w2;
        for (i = 0; i < w2; i++) begin
          if (!l2_val[vset2][i]) begin
            slot = i;
            break;
          end
        end
        if (slot == w2) begin
          slot = 0;
          for (i = 1; i < w2; i++)
            if (l2_stp[vset2][i] < l2_stp[vset2][slot]) slot = i;
        end
        l2_val[vset2][slot] = 1;
        l2_tag[vset2][slot] = vtag2[ABITS-1:0];
        l2_stp[vset2][slot] = now;
      end
    end

    access_cnt = now + 32'd1;
    r.mem_read_count  = n_mrd;
    r.mem_write_count = n_mwr;
    r.l1_hit_count    = n_l1h;
    r.l1_miss_count   = n_l1m;
    r.l2_hit_count    = n_l2h;
    r.l2_miss_count   = n_l2m;
    return r;
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Random address: mostly tags that collide in a few sets of the phase.
  function automatic logic [ABITS-1:0] pick_addr();
    int unsigned b, s1, k;
    logic [63:0] a;
    b  = (g_blk > 16) ? 16 : g_blk;
    s1 = (g_s1 > 6) ? 6 : g_s1;
    if ($urandom_range(99) < 15) return ABITS'({$urandom, $urandom});
    k = $urandom_range(2 * (L1_WAYS + L2_WAYS) / 3);
    a = {16'd0, pool_base} ^ (64'(k) << (b + s1)) ^ (64'($urandom_range(1)) << b);
    if (b > 0) a = a ^ (64'($urandom) & ((64'd1 << b) - 1));
    return a[ABITS-1:0];
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      n_err++;
    end
  endfunction

  // Sends one access and records its predicted response at acceptance.
  task automatic send_access(logic wr, logic [ABITS-1:0] a);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid    <= 1'b1;
    req.req_type <= wr;
    req.address  <= a;
    do @(posedge clk_i); while (!req.ready);
    pending_rsp.push_back(predict_access(wr, a));
    n_sent++;
  endtask

  // Waits until every response has arrived, then lets the block settle.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes a register; the caller lowers the write enable after a batch.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      REG_L1_SET_BITS: g_s1  = data[2:0];
      REG_L1_WAYS:     g_w1  = data[3:0];
      REG_L2_SET_BITS: g_s2  = data[3:0];
      REG_L2_WAYS:     g_w2  = data[4:0];
      REG_BLOCK_BITS:  g_blk = data[4:0];
      REG_L1_LRU:      g_lru = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_geometry(geom_set_t g);
    write_reg(REG_L1_SET_BITS, CFG_DATA_W'(g.s1));
    write_reg(REG_L1_WAYS,     CFG_DATA_W'(g.w1));
    write_reg(REG_L2_SET_BITS, CFG_DATA_W'(g.s2));
    write_reg(REG_L2_WAYS,     g.w2);
    write_reg(REG_BLOCK_BITS,  g.blk);
    write_reg(REG_L1_LRU,      CFG_DATA_W'(g.lru));
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Response side: checks each transaction and stalls at random.
  initial begin
    cache_rsp_t  e;
    int unsigned stall;
    stall = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          $error("response transaction with no access outstanding");
          n_err++;
        end else begin
          e = pending_rsp.pop_front();
          check_field("l1_hit",          32'(e.l1_hit),     32'(rsp.l1_hit));
          check_field("l2_hit",          32'(e.l2_hit),     32'(rsp.l2_hit));
          check_field("mem_read",        32'(e.mem_read),   32'(rsp.mem_read));
          check_field("mem_write",       32'(e.mem_write),  32'(rsp.mem_write));
          check_field("mem_read_count",  e.mem_read_count,  rsp.mem_read_count);
          check_field("mem_write_count", e.mem_write_count, rsp.mem_write_count);
          check_field("l1_hit_count",    e.l1_hit_count,    rsp.l1_hit_count);
          check_field("l1_miss_count",   e.l1_miss_count,   rsp.l1_miss_count);
          check_field("l2_hit_count",    e.l2_hit_count,    rsp.l2_hit_count);
          check_field("l2_miss_count",   e.l2_miss_count,   rsp.l2_miss_count);
          n_seen_l1h += e.l1_hit;
          n_seen_l2h += e.l2_hit;
          n_seen_mrd += e.mem_read;
        end
      end
      if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < 20) begin
        stall = pick_gap();
        rsp.ready <= (stall == 0);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed table, then random phases under varied geometry.
  initial begin
    dir_row_t    dir_tbl[$];
    geom_set_t   geoms[N_PHASES];
    cache_rsp_t  e;
    int unsigned i, p;
    req.valid    <= 1'b0;
    req.req_type <= RD;
    req.address  <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_L1_SET_BITS;
    cfg_data     <= '0;
    access_cnt = '0;
    {n_mrd, n_mwr, n_l1h, n_l1m, n_l2h, n_l2m} = '0;
    n_err = 0;
    n_sent = 0;
    quiet = 0;

    // Directed rows under the reset geometry: 64-byte blocks, 64 L1 sets.
    dir_tbl.push_back('{RD, 48'h0,             1, 4'b0010});
    dir_tbl.push_back('{WR, 48'h0,             1, 4'b1001});
    dir_tbl.push_back('{RD, 48'h3F,            1, 4'b1000});
    dir_tbl.push_back('{WR, 48'hFFFF_FFFF_FFFF, 1, 4'b0011});
    dir_tbl.push_back('{RD, 48'hFFFF_FFFF_FFC0, 1, 4'b1000});
    // Fill set 0 of L1 and push the oldest line, address zero, into L2.
    for (i = 1; i <= 8; i++)
      dir_tbl.push_back('{(i % 2 == 1) ? WR : RD, 48'(i) << 12, 0, 4'b0000});
    dir_tbl.push_back('{RD, 48'h0,             1, 4'b0100});
    dir_tbl.push_back('{WR, 48'h1000,          1, 4'b0101});
    dir_tbl.push_back('{RD, 48'hAAAA_AAAA_AAAA, 0, 4'b0000});
    dir_tbl.push_back('{WR, 48'h5555_5555_5555, 0, 4'b0000});
    dir_tbl.push_back('{RD, 48'h8000_0000_0000, 0, 4'b0000});

    // Geometry of each random phase, the extremes and clamped values among them.
    geoms[0] = '{3'd6, 4'd8,  4'd9,  5'd16, 5'd6,  1'b0};
    geoms[1] = '{3'd7, 4'd15, 4'd15, 5'd31, 5'd31, 1'b1};
    geoms[2] = '{3'd0, 4'd0,  4'd0,  5'd0,  5'd0,  1'b0};
    geoms[3] = '{3'd0, 4'd2,  4'd0,  5'd3,  5'd16, 1'b1};
    geoms[4] = '{3'd2, 4'd3,  4'd1,  5'd4,  5'd4,  1'b1};
    geoms[5] = '{3'd3, 4'd4,  4'd2,  5'd2,  5'd0,  1'b0};
    geoms[6] = '{3'd6, 4'd8,  4'd9,  5'd16, 5'd17, 1'b1};
    geoms[7] = '{3'd1, 4'd5,  4'd4,  5'd6,  5'd2,  1'b0};

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Directed part; flagged rows are also compared with the typed-in flags.
    foreach (dir_tbl[k]) begin
      send_access(dir_tbl[k].wr, dir_tbl[k].addr);
      e = pending_rsp[pending_rsp.size() - 1];
      if (dir_tbl[k].has_flags &&
          {e.l1_hit, e.l2_hit, e.mem_read, e.mem_write} !== dir_tbl[k].flags) begin
        $error("directed row %0d: flags expected %b", k, dir_tbl[k].flags);
        n_err++;
      end
    end
    drain();

    // Writes to undecoded indexes must change nothing.
    write_reg(REG_SPARE_A, 5'h1F);
    write_reg(REG_SPARE_B, 5'h00);
    cfg_we <= 1'b0;
    @(posedge clk_i);

    // Random phases.
    for (p = 0; p < N_PHASES; p++) begin
      apply_geometry(geoms[p]);
      pool_base = ABITS'({$urandom, $urandom});
      quiet = (p % 3 == 1);
      for (i = 0; i < PHASE_N; i++) begin
        // In one phase, the sender holds off until every response is back.
        if (p == 4 && i % 8 == 0) begin
          req.valid <= 1'b0;
          while (pending_rsp.size() != 0) @(posedge clk_i);
          @(posedge clk_i);
        end
        send_access(1'($urandom), pick_addr());
      end
      drain();
    end

    $display("Sent %0d accesses over %0d geometries: %0d L1 hits, %0d L2 hits,",
             n_sent, N_PHASES + 1, n_seen_l1h, n_seen_l2h);
    $display("%0d memory reads; FIFO and LRU, clamped and minimal geometries.",
             n_seen_mrd);
    if (n_err == 0 && pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tec_pkg.sv
rtl/tec_if.sv
rtl/tec_ram.sv
rtl/tec_split.sv
rtl/two_level_exclusive_cache.sv
test/two_level_exclusive_cache_tb.sv
